// File: rtl/core/swv_pkg.sv
// ----------------------------------------------------------------------------
// swv_pkg
// shared constants, types and the arctangent table for the wheel vector solver
// ----------------------------------------------------------------------------
`default_nettype none
package swv_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 24;

  localparam logic signed [31:0] K_Q30        = 32'sd652032874;
  localparam int                 HALF_TURN    = 11520;
  localparam int                 QUARTER_TURN = 5760;
  localparam int                 FULL_TURN    = 23040;

  // configuration register indexes
  localparam logic [2:0] REG_DEADBAND = 3'd0;
  localparam logic [2:0] REG_SCALE    = 3'd1;
  localparam logic [2:0] REG_LF_ANGLE = 3'd2;
  localparam logic [2:0] REG_LB_ANGLE = 3'd3;
  localparam logic [2:0] REG_RF_ANGLE = 3'd4;
  localparam logic [2:0] REG_RB_ANGLE = 3'd5;

  localparam int AW = 32;   // angle: 1/64 deg with 16 fraction bits
  localparam int RW = 34;   // rotation x/y, Q1.30 with headroom
  localparam int VW = 44;   // vectoring x/y, Q.24 with headroom

  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [VW-1:0] vec_t;

  typedef struct packed {
    rot_t x;
    rot_t y;
    ang_t z;
    logic neg;
  } rcell_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic zero;
  } vcell_t;

  function automatic ang_t atan_val(input int i);
    ang_t r;
    case (i)
      0: r = 32'sd188743680;
      1: r = 32'sd111421900;
      2: r = 32'sd58872272;
      3: r = 32'sd29884485;
      4: r = 32'sd15000234;
      5: r = 32'sd7507429;
      6: r = 32'sd3754631;
      7: r = 32'sd1877430;
      8: r = 32'sd938729;
      9: r = 32'sd469366;
      10: r = 32'sd234683;
      11: r = 32'sd117342;
      12: r = 32'sd58671;
      13: r = 32'sd29335;
      14: r = 32'sd14668;
      15: r = 32'sd7334;
      16: r = 32'sd3667;
      17: r = 32'sd1833;
      18: r = 32'sd917;
      19: r = 32'sd458;
      20: r = 32'sd229;
      21: r = 32'sd115;
      22: r = 32'sd57;
      23: r = 32'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/swv_rot_cell.sv
// ----------------------------------------------------------------------------
// swv_rot_cell
// one rotation-mode cordic iteration with a register stage
// ----------------------------------------------------------------------------
`default_nettype none
module swv_rot_cell (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [4:0]       step,
  input  swv_pkg::rcell_t       d_in,
  output swv_pkg::rcell_t       d_out
);
  import swv_pkg::*;

  rcell_t cell_r;
  rcell_t cell_nxt;
  rot_t   xs;
  rot_t   ys;

  always_comb begin
    xs       = d_in.x >>> step;
    ys       = d_in.y >>> step;
    cell_nxt = d_in;
    if (!d_in.z[AW-1]) begin
      cell_nxt.x = d_in.x - ys;
      cell_nxt.y = d_in.y + xs;
      cell_nxt.z = d_in.z - atan_val(int'(step));
    end else begin
      cell_nxt.x = d_in.x + ys;
      cell_nxt.y = d_in.y - xs;
      cell_nxt.z = d_in.z + atan_val(int'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;
endmodule
`default_nettype wire

// File: rtl/core/swv_vec_cell.sv
// ----------------------------------------------------------------------------
// swv_vec_cell
// one vectoring-mode cordic iteration with a register stage
// ----------------------------------------------------------------------------
`default_nettype none
module swv_vec_cell (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [4:0]       step,
  input  swv_pkg::vcell_t       d_in,
  output swv_pkg::vcell_t       d_out
);
  import swv_pkg::*;

  vcell_t cell_r;
  vcell_t cell_nxt;
  vec_t   xs;
  vec_t   ys;

  always_comb begin
    xs       = d_in.x >>> step;
    ys       = d_in.y >>> step;
    cell_nxt = d_in;
    if (!d_in.y[VW-1]) begin
      cell_nxt.x = d_in.x + ys;
      cell_nxt.y = d_in.y - xs;
      cell_nxt.z = d_in.z + atan_val(int'(step));
    end else begin
      cell_nxt.x = d_in.x - ys;
      cell_nxt.y = d_in.y + xs;
      cell_nxt.z = d_in.z - atan_val(int'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;
endmodule
`default_nettype wire

// File: rtl/core/swv_wheel.sv
// ----------------------------------------------------------------------------
// swv_wheel
// per-corner pipeline: angle reduce, rotation chain, turn product, vectoring
// chain and magnitude scaling
// ----------------------------------------------------------------------------
`default_nettype none
module swv_wheel (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] corner_angle,
  input  wire logic signed [15:0] heading,
  input  wire logic signed [31:0] cx,
  input  wire logic signed [31:0] cy,
  input  wire logic signed [31:0] rot,
  output logic [15:0]             speed,
  output logic signed [14:0]      dir
);
  import swv_pkg::*;

  localparam int NS = CORDIC_STEPS;

  // stage a: angle reduction
  logic signed [17:0] d0, d1, d2;
  logic               neg0;
  rcell_t             r_in;
  logic signed [31:0] cx_a_r, cy_a_r, rot_a_r;
  rcell_t             r_chain [NS+1];
  logic signed [31:0] cx_p_r [NS+1];
  logic signed [31:0] cy_p_r [NS+1];
  logic signed [31:0] rt_p_r [NS+1];

  always_comb begin
    d0 = 18'(corner_angle) - 18'(heading);
    d1 = d0;
    // three passes cover any difference of two 16-bit angles
    for (int j = 0; j < 3; j++) begin
      if (d1 > 18'(HALF_TURN)) d1 = d1 - 18'(FULL_TURN);
      else if (d1 <= -18'(HALF_TURN)) d1 = d1 + 18'(FULL_TURN);
    end
    neg0 = 1'b0;
    d2   = d1;
    if (d1 > 18'(QUARTER_TURN)) begin
      d2 = d1 - 18'(HALF_TURN);
      neg0 = 1'b1;
    end else if (d1 < -18'(QUARTER_TURN)) begin
      d2 = d1 + 18'(HALF_TURN);
      neg0 = 1'b1;
    end
    r_in.x   = RW'(K_Q30);
    r_in.y   = '0;
    r_in.z   = {d2[15:0], 16'h0000};
    r_in.neg = neg0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_chain[0] <= r_in;
      cx_p_r[0]  <= cx;
      cy_p_r[0]  <= cy;
      rt_p_r[0]  <= rot;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    swv_rot_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (5'(i)),
      .d_in (r_chain[i]),
      .d_out(r_chain[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        cx_p_r[i+1] <= cx_p_r[i];
        cy_p_r[i+1] <= cy_p_r[i];
        rt_p_r[i+1] <= rt_p_r[i];
      end
    end
  end

  // turn products
  rot_t               c_v, s_v;
  logic signed [65:0] pc_r, ps_r;
  logic signed [31:0] cx_m_r, cy_m_r;

  always_comb begin
    c_v = r_chain[NS].neg ? -r_chain[NS].x : r_chain[NS].x;
    s_v = r_chain[NS].neg ? -r_chain[NS].y : r_chain[NS].y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r   <= 66'(rt_p_r[NS]) * 66'(c_v);
      ps_r   <= 66'(rt_p_r[NS]) * 66'(s_v);
      cx_m_r <= cx_p_r[NS];
      cy_m_r <= cy_p_r[NS];
    end
  end

  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic [65:0] a;
    logic [65:0] q;
    a = v[65] ? 66'(-v) : 66'(v);
    q = (a + 66'(1 << 29)) >> 30;
    return v[65] ? -36'(q) : 36'(q);
  endfunction

  // vector start: fold into right half plane
  vec_t   vx, vy;
  vcell_t v_in;
  vcell_t v_chain [NS+1];

  always_comb begin
    vx = VW'(cx_m_r) - VW'(rnd30(pc_r));
    vy = VW'(cy_m_r) - VW'(rnd30(ps_r));
    v_in.zero = (vx == '0) && (vy == '0);
    v_in.z    = '0;
    v_in.x    = vx;
    v_in.y    = vy;
    if (vx[VW-1]) begin
      v_in.z = vy[VW-1] ? -ang_t'(HALF_TURN * 65536) : ang_t'(HALF_TURN * 65536);
      v_in.x = -vx;
      v_in.y = -vy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_chain[0] <= v_in;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    swv_vec_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (5'(i)),
      .d_in (v_chain[i]),
      .d_out(v_chain[i+1])
    );
  end

  // magnitude gain and angle rounding
  logic [75:0]        mk_r;
  logic signed [14:0] dir_r;
  logic               zero_r;
  logic signed [31:0] zr;
  logic [VW-1:0]      xpos;
  logic [31:0]        zabs;

  always_comb begin
    zabs = v_chain[NS].z[AW-1] ? 32'(-v_chain[NS].z) : 32'(v_chain[NS].z);
    zabs = (zabs + 32'd32768) >> 16;
    zr   = v_chain[NS].z[AW-1] ? -32'(zabs) : 32'(zabs);
    if (zr > 32'(HALF_TURN)) zr = 32'(HALF_TURN);
    if (zr < -32'(HALF_TURN)) zr = -32'(HALF_TURN);
    xpos = v_chain[NS].x[VW-1] ? '0 : v_chain[NS].x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mk_r   <= 76'(xpos) * 76'(K_Q30);
      dir_r  <= zr[14:0];
      zero_r <= v_chain[NS].zero;
    end
  end

  logic [75:0] m1, m2;
  always_comb begin
    m1 = (mk_r + 76'(1 << 29)) >> 30;
    m2 = (m1 + 76'(1 << 13)) >> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed <= zero_r ? 16'd0 : ((m2 > 76'd65535) ? 16'hFFFF : m2[15:0]);
      dir   <= zero_r ? 15'sd0 : dir_r;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/swerve_wheel_vector_solver.sv
// ----------------------------------------------------------------------------
// swerve_wheel_vector_solver
// swerve drive inverse kinematics: four corner cordic pipelines
//
// channel   ports              role
// in        in_valid/in_ready  stick x, y, turn and heading request
// out       out_valid/out_ready per-corner speed and direction
// cfg       cfg_we/cfg_index   deadband, scale and corner angles
//
// one request per cycle unless the output stalls; requests pass through the
// rotation and vectoring cell chains. the whole pipe advances when the last
// stage is empty or taken, so a stalled output holds every stage.
// reset clears the stage valid bits and the config registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module swerve_wheel_vector_solver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_stick_x,
  input  wire logic signed [15:0] in_stick_y,
  input  wire logic signed [15:0] in_turn,
  input  wire logic signed [15:0] in_heading,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_lf_speed,
  output logic [15:0]             out_lb_speed,
  output logic [15:0]             out_rf_speed,
  output logic [15:0]             out_rb_speed,
  output logic signed [14:0]      out_lf_dir,
  output logic signed [14:0]      out_lb_dir,
  output logic signed [14:0]      out_rf_dir,
  output logic signed [14:0]      out_rb_dir,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import swv_pkg::*;

  localparam int LAT = 2 * CORDIC_STEPS + 6;

  logic [14:0]        deadband_r, scale_r;
  logic signed [15:0] ang_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= 15'd3277;
      scale_r    <= 15'd11776;
      for (int k = 0; k < 4; k++) ang_r[k] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADBAND: deadband_r <= cfg_data[14:0];
        REG_SCALE:    scale_r    <= cfg_data[14:0];
        REG_LF_ANGLE: ang_r[0]   <= cfg_data;
        REG_LB_ANGLE: ang_r[1]   <= cfg_data;
        REG_RF_ANGLE: ang_r[2]   <= cfg_data;
        REG_RB_ANGLE: ang_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [LAT-1:0] vld_r;
  logic           en;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  function automatic logic signed [15:0] dband(input logic signed [15:0] v,
                                               input logic [14:0] db);
    logic [16:0] mag;
    mag = v[15] ? 17'(-17'(v)) : 17'(v);
    return (mag < 17'(db)) ? 16'sd0 : v;
  endfunction

  // input stage: deadband and scale products
  logic signed [31:0] cx_r, cy_r, rot_r;
  logic signed [15:0] hd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r  <= -(32'(dband(in_stick_y, deadband_r)) * 32'(scale_r));
      cy_r  <= 32'(dband(in_stick_x, deadband_r)) * 32'(scale_r);
      rot_r <= 32'(dband(in_turn, deadband_r)) * 32'(scale_r);
      hd_r  <= in_heading;
    end
  end

  logic [15:0]        spd [4];
  logic signed [14:0] dr  [4];

  for (genvar k = 0; k < 4; k++) begin : g_wheel
    swv_wheel u_wheel (
      .clk         (clk),
      .en          (en),
      .corner_angle(ang_r[k]),
      .heading     (hd_r),
      .cx          (cx_r),
      .cy          (cy_r),
      .rot         (rot_r),
      .speed       (spd[k]),
      .dir         (dr[k])
    );
  end

  assign out_lf_speed = spd[0];
  assign out_lb_speed = spd[1];
  assign out_rf_speed = spd[2];
  assign out_rb_speed = spd[3];
  assign out_lf_dir   = dr[0];
  assign out_lb_dir   = dr[1];
  assign out_rf_dir   = dr[2];
  assign out_rb_dir   = dr[3];
endmodule
`default_nettype wire

// File: bench/swv_checker.sv
// ----------------------------------------------------------------------------
// swv_checker
// Watches the request, result and register ports of the wheel vector solver.
// For each accepted request it computes the speed and direction of every
// corner with its own cordic model and its own copy of the registers. Each
// accepted result is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module swv_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_stick_x,
  input  logic signed [15:0] in_stick_y,
  input  logic signed [15:0] in_turn,
  input  logic signed [15:0] in_heading,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        out_lf_speed,
  input  logic [15:0]        out_lb_speed,
  input  logic [15:0]        out_rf_speed,
  input  logic [15:0]        out_rb_speed,
  input  logic signed [14:0] out_lf_dir,
  input  logic signed [14:0] out_lb_dir,
  input  logic signed [14:0] out_rf_dir,
  input  logic signed [14:0] out_rb_dir,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import swv_pkg::*;

  typedef struct {
    logic [15:0]        speed [4];
    logic signed [14:0] dir   [4];
  } wheel_set_t;

  localparam longint ARCTAN [MAX_STEPS] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  localparam string SPEED_NAME [4] = '{"lf_speed", "lb_speed", "rf_speed", "rb_speed"};
  localparam string DIR_NAME   [4] = '{"lf_dir", "lb_dir", "rf_dir", "rb_dir"};

  logic [14:0]        db_q;
  logic [14:0]        gain_q;
  logic signed [15:0] corner_q [4];
  wheel_set_t         wheel_q [$];

  function automatic longint round_away(longint v, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic int deadbanded(logic signed [15:0] v);
    int m;
    m = (v < 0) ? -int'(v) : int'(v);
    return (m < int'(db_q)) ? 0 : int'(v);
  endfunction

  function automatic void corner_sincos(int d, output longint c, output longint s);
    longint x, y, z, xs, ys;
    logic flip;
    x = K_Q30;
    y = 0;
    flip = 1'b0;
    while (d > HALF_TURN) d -= FULL_TURN;
    while (d <= -HALF_TURN) d += FULL_TURN;
    if (d > QUARTER_TURN) begin
      d -= HALF_TURN;
      flip = 1'b1;
    end else if (d < -QUARTER_TURN) begin
      d += HALF_TURN;
      flip = 1'b1;
    end
    z = longint'(d) * 65536;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end else begin
        x += ys; y -= xs; z += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void wheel_vector(longint x, longint y, output logic [15:0] spd,
                                       output logic signed [14:0] dir);
    longint z, xs, ys, d;
    longint unsigned m;
    z = 0;
    if (x == 0 && y == 0) begin
      spd = '0;
      dir = '0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0 ? longint'(HALF_TURN) : -longint'(HALF_TURN)) * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ARCTAN[i];
      end else begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end
    end
    d = round_away(z, 16);
    if (d > HALF_TURN) d = HALF_TURN;
    if (d < -HALF_TURN) d = -HALF_TURN;
    dir = d[14:0];
    if (x < 0) x = 0;
    m = (longint'(x) * longint'(K_Q30) + (64'd1 << 29)) >> 30;
    m = (m + (64'd1 << 13)) >> 14;
    spd = (m > 65535) ? 16'hFFFF : m[15:0];
  endfunction

  function automatic wheel_set_t solve_wheels(logic signed [15:0] sx_in,
      logic signed [15:0] sy_in, logic signed [15:0] tr_in, logic signed [15:0] hd);
    wheel_set_t w;
    longint g, cx, cy, rot, c, s;
    g = longint'(gain_q);
    cx = -(longint'(deadbanded(sy_in)) * g);
    cy = longint'(deadbanded(sx_in)) * g;
    rot = longint'(deadbanded(tr_in)) * g;
    for (int k = 0; k < 4; k++) begin
      corner_sincos(int'(corner_q[k]) - int'(hd), c, s);
      wheel_vector(cx - round_away(rot * c, 30), cy - round_away(rot * s, 30),
                   w.speed[k], w.dir[k]);
    end
    return w;
  endfunction

  assign pending = wheel_q.size();

  always @(posedge clk) begin
    wheel_set_t want;
    logic [15:0]        got_speed [4];
    logic signed [14:0] got_dir   [4];
    if (!rst_n) begin
      db_q = 15'd3277;
      gain_q = 15'd11776;
      for (int k = 0; k < 4; k++) corner_q[k] = '0;
      wheel_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEADBAND: db_q = cfg_data[14:0];
          REG_SCALE:    gain_q = cfg_data[14:0];
          REG_LF_ANGLE: corner_q[0] = cfg_data;
          REG_LB_ANGLE: corner_q[1] = cfg_data;
          REG_RF_ANGLE: corner_q[2] = cfg_data;
          REG_RB_ANGLE: corner_q[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        wheel_q.push_back(solve_wheels(in_stick_x, in_stick_y, in_turn, in_heading));
      if (out_valid && out_ready) begin
        got_speed = '{out_lf_speed, out_lb_speed, out_rf_speed, out_rb_speed};
        got_dir = '{out_lf_dir, out_lb_dir, out_rf_dir, out_rb_dir};
        if (wheel_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = wheel_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got_speed[k] !== want.speed[k]) begin
              $error("%s expected %0d got %0d", SPEED_NAME[k], want.speed[k], got_speed[k]);
              errors++;
            end
            if (got_dir[k] !== want.dir[k]) begin
              $error("%s expected %0d got %0d", DIR_NAME[k], want.dir[k], got_dir[k]);
              errors++;
            end
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_swerve_wheel_vector_solver.sv
// ----------------------------------------------------------------------------
// tb_swerve_wheel_vector_solver
// Drives the wheel vector solver through several register settings, from
// defaults to the extremes, with directed corner cases and random requests
// under random gaps and output stalls. The checker module judges the results.
// ----------------------------------------------------------------------------
module tb_swerve_wheel_vector_solver;
  import swv_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_stick_x;
  logic signed [15:0] in_stick_y;
  logic signed [15:0] in_turn;
  logic signed [15:0] in_heading;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_lf_speed, out_lb_speed, out_rf_speed, out_rb_speed;
  logic signed [14:0] out_lf_dir, out_lb_dir, out_rf_dir, out_rb_dir;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 errors;
  int                 pending;
  logic               long_hold;
  logic               free_run;
  int                 cur_db;

  swerve_wheel_vector_solver uut (.*);

  swv_checker chk (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
      end else if (free_run || $urandom_range(0, 99) < 70) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_DEADBAND) cur_db = int'(val);
  endtask

  task automatic set_regs(int db, int gain, int lf, int lb, int rf, int rb);
    write_reg(REG_DEADBAND, 16'(db));
    write_reg(REG_SCALE, 16'(gain));
    write_reg(REG_LF_ANGLE, 16'(lf));
    write_reg(REG_LB_ANGLE, 16'(lb));
    write_reg(REG_RF_ANGLE, 16'(rf));
    write_reg(REG_RB_ANGLE, 16'(rb));
  endtask

  task automatic send(int x, int y, int t, int h);
    in_stick_x = 16'(x);
    in_stick_y = 16'(y);
    in_turn = 16'(t);
    in_heading = 16'(h);
    in_valid = 1'b1;
    @(posedge clk iff in_ready);
    @(negedge clk);
  endtask

  task automatic gap();
    int r;
    r = $urandom_range(0, 99);
    if (free_run || r < 55) return;
    in_valid = 1'b0;
    if (r < 92) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 40)) @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * CORDIC_STEPS + 12) @(negedge clk);
  endtask

  function automatic int stick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 32768) - 16384;
    if (r < 75) return ($urandom_range(0, 1) ? 1 : -1) * (cur_db + $urandom_range(0, 4) - 2);
    if (r < 90) return int'($signed(16'($urandom())));
    return 0;
  endfunction

  function automatic int heading_value();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 46080) - 23040;
    return int'($signed(16'($urandom())));
  endfunction

  task automatic random_items(int n, int hold_at, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) long_hold = 1'b1;
      if (i == pause_at) drain();
      if (i == n / 3) free_run = 1'b1;
      if (i == n / 3 + 30) free_run = 1'b0;
      send(stick_value(), stick_value(), stick_value(), heading_value());
      gap();
    end
  endtask

  task automatic corner_items();
    send(0, 0, 0, 0);
    send(16384, 0, 0, 0);
    send(-16384, 0, 0, 0);
    send(0, 16384, 0, 0);
    send(0, -16384, 0, 0);
    send(0, 0, 16384, 0);
    send(0, 0, -16384, 23040);
    send(16384, 16384, 16384, -23040);
    send(-16384, -16384, -16384, 11520);
    send(-32768, -32768, -32768, -32768);
    send(32767, 32767, 32767, 32767);
    send(cur_db, -cur_db, cur_db - 1, -11520);
    send(-(cur_db - 1), cur_db - 1, -cur_db, 5760);
    send(0, 0, 16384, -5760);
    send(16384, 0, 16384, 17280);
    in_valid = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stick_x = '0;
    in_stick_y = '0;
    in_turn = '0;
    in_heading = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    long_hold = 1'b0;
    free_run = 1'b0;
    cur_db = 3277;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    corner_items();
    random_items(30, -1, -1);
    drain();

    set_regs(0, 32767, 23040, -23040, 8640, -2880);
    corner_items();
    random_items(80, 20, -1);
    drain();

    set_regs(16384, 0, -32768, 32767, 0, 11520);
    random_items(40, -1, -1);
    drain();

    set_regs(1638, 10240, 2880, 8640, -2880, -8640);
    random_items(280, 40, 150);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
